// ===== rtl/core/spm_pkg.sv =====
// Package: shared widths, reset values, codes and types of the servo PWM generator.
`default_nettype none

package spm_pkg;

  localparam int PERIOD_W    = 20;
  localparam int PULSE_W     = 20;
  localparam int CPD_W       = 12;
  localparam int ANGLE_W     = 8;
  localparam int DELTA_W     = 9;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int COUNT_W_DEF = 20;

  // angle * cycles_per_degree, and min_pulse plus that product
  localparam int PROD_W     = ANGLE_W + CPD_W;
  localparam int HIGH_SUM_W = ((PULSE_W > PROD_W) ? PULSE_W : PROD_W) + 1;

  localparam logic [PERIOD_W-1:0] RST_PERIOD    = PERIOD_W'(360000);
  localparam logic [PULSE_W-1:0]  RST_MIN_PULSE = PULSE_W'(18000);
  localparam logic [CPD_W-1:0]    RST_CPD       = CPD_W'(100);
  localparam logic [ANGLE_W-1:0]  RST_MAX_ANGLE = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0]  CENTER_ANGLE  = ANGLE_W'(90);

  // high time for the center angle at reset register values
  localparam int RESET_HIGH_RAW = int'(RST_MIN_PULSE) + int'(CENTER_ANGLE) * int'(RST_CPD);
  localparam int RESET_HIGH     = (RESET_HIGH_RAW > int'(RST_PERIOD)) ?
                                  int'(RST_PERIOD) : RESET_HIGH_RAW;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_ABS  = 2'd1,
    OP_REL  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_MIN_PULSE = 2'd1,
    CFG_CPD       = 2'd2,
    CFG_MAX_ANGLE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PULSE_W-1:0]  min_pulse;
    logic [CPD_W-1:0]    cpd;
    logic [ANGLE_W-1:0]  max_angle;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [ANGLE_W-1:0]        abs_angle;
    logic signed [DELTA_W-1:0] rel_delta;
  } cmd_t;

  typedef struct packed {
    logic               pwm_level;
    logic [ANGLE_W-1:0] pending_angle;
    logic [ANGLE_W-1:0] active_angle;
  } res_t;

  typedef struct packed {
    logic               phase_high;
    logic [ANGLE_W-1:0] cur_angle;
    logic [ANGLE_W-1:0] nxt_angle;
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/spm_if.sv =====
// Interfaces: command input, result output and register write channels.
`default_nettype none

interface spm_in_if;
  import spm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [ANGLE_W-1:0]        abs_angle;
  logic signed [DELTA_W-1:0] rel_delta;

  modport source (output valid, op, abs_angle, rel_delta, input ready);
  modport sink   (input valid, op, abs_angle, rel_delta, output ready);
endinterface

interface spm_out_if;
  import spm_pkg::*;
  logic               valid;
  logic               ready;
  logic               pwm_level;
  logic [ANGLE_W-1:0] pending_angle;
  logic [ANGLE_W-1:0] active_angle;

  modport source (output valid, pwm_level, pending_angle, active_angle, input ready);
  modport sink   (input valid, pwm_level, pending_angle, active_angle, output ready);
endinterface

interface spm_cfg_if;
  import spm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spm_cfg_regs.sv =====
// Configuration register file: period, minimum pulse, cycles per degree, max angle.
`default_nettype none

module spm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [spm_pkg::CFG_DATA_W-1:0] wdata_i,
  output spm_pkg::cfg_t                  cfg_o
);
  import spm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_PERIOD:    cfg_d.period    = wdata_i[PERIOD_W-1:0];
        CFG_MIN_PULSE: cfg_d.min_pulse = wdata_i[PULSE_W-1:0];
        CFG_CPD:       cfg_d.cpd       = wdata_i[CPD_W-1:0];
        CFG_MAX_ANGLE: cfg_d.max_angle = wdata_i[ANGLE_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period    <= RST_PERIOD;
      cfg_q.min_pulse <= RST_MIN_PULSE;
      cfg_q.cpd       <= RST_CPD;
      cfg_q.max_angle <= RST_MAX_ANGLE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/spm_core.sv =====
// Servo state update: period counter, angle latch, high time and command clamping.
`default_nettype none

module spm_core #(
  parameter int CountWidth = spm_pkg::COUNT_W_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spm_pkg::cmd_t   cmd_i,
  input  spm_pkg::cfg_t   cfg_i,
  output spm_pkg::res_t   res_o,
  output spm_pkg::state_t st_o
);
  import spm_pkg::*;

  localparam int CalcW = (CountWidth > HIGH_SUM_W) ? CountWidth : HIGH_SUM_W;
  localparam logic [CountWidth-1:0] HighRst = CountWidth'(RESET_HIGH);
  localparam int RelW = ANGLE_W + 2;

  logic                  phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] high_q, high_d;
  logic [ANGLE_W-1:0]    cur_q, cur_d;
  logic [ANGLE_W-1:0]    nxt_q, nxt_d;

  logic [CountWidth-1:0] count_inc;
  logic                  wrap;
  logic [PROD_W-1:0]     prod;
  logic [CalcW-1:0]      high_sum;
  logic [CalcW-1:0]      high_cap;
  logic [CountWidth-1:0] high_new;
  logic [ANGLE_W-1:0]    abs_clamped;
  logic signed [RelW-1:0] rel_sum;
  logic [ANGLE_W-1:0]    rel_clamped;

  assign count_inc = count_q + CountWidth'(1);
  assign wrap      = CalcW'(count_inc) >= CalcW'(cfg_i.period);

  // high time for the pending angle, used only at a period start
  assign prod     = PROD_W'(nxt_q) * PROD_W'(cfg_i.cpd);
  assign high_sum = CalcW'(cfg_i.min_pulse) + CalcW'(prod);
  assign high_cap = (high_sum > CalcW'(cfg_i.period)) ? CalcW'(cfg_i.period) : high_sum;
  assign high_new = high_cap[CountWidth-1:0];

  assign abs_clamped = (cmd_i.abs_angle > cfg_i.max_angle) ? cfg_i.max_angle
                                                            : cmd_i.abs_angle;

  // relative move from the angle in force, clamped to zero and max angle
  assign rel_sum = $signed({2'b00, cur_q})
                 + $signed({{(RelW-DELTA_W){cmd_i.rel_delta[DELTA_W-1]}}, cmd_i.rel_delta});

  always_comb begin
    if (rel_sum[RelW-1]) begin
      rel_clamped = '0;
    end else if (rel_sum[ANGLE_W:0] > (ANGLE_W+1)'(cfg_i.max_angle)) begin
      rel_clamped = cfg_i.max_angle;
    end else begin
      rel_clamped = rel_sum[ANGLE_W-1:0];
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    high_d  = high_q;
    cur_d   = cur_q;
    nxt_d   = nxt_q;
    if (push_i) begin
      case (op_e'(cmd_i.op))
        OP_TICK: begin
          if (wrap) begin
            count_d = '0;
            cur_d   = nxt_q;
            high_d  = high_new;
            phase_d = (high_new != '0);
          end else begin
            count_d = count_inc;
            phase_d = (count_inc < high_q);
          end
        end
        OP_ABS:  nxt_d = abs_clamped;
        OP_REL:  nxt_d = rel_clamped;
        default: nxt_d = nxt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b1;
      count_q <= '0;
      high_q  <= HighRst;
      cur_q   <= CENTER_ANGLE;
      nxt_q   <= CENTER_ANGLE;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      high_q  <= high_d;
      cur_q   <= cur_d;
      nxt_q   <= nxt_d;
    end
  end

  // result word reflects the state after this item
  assign res_o.pwm_level     = phase_d;
  assign res_o.pending_angle = nxt_d;
  assign res_o.active_angle  = cur_d;

  assign st_o.phase_high = phase_q;
  assign st_o.cur_angle  = cur_q;
  assign st_o.nxt_angle  = nxt_q;

endmodule

`default_nettype wire

// ===== rtl/core/spm_out_buf.sv =====
// Two-entry output stage: result register plus skid register.
`default_nettype none

module spm_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spm_pkg::res_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          ready_i,
  output spm_pkg::res_t data_o
);
  import spm_pkg::*;

  logic main_v_q, main_v_d;
  logic skid_v_q, skid_v_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = main_v_q && ready_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else if (push_i) begin
        main_d = data_i;
      end else begin
        main_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q) begin
        main_d   = data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = data_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

endmodule

`default_nettype wire

// ===== rtl/core/servo_pwm_position_generator_top.sv =====
// Top level of the servo PWM position generator.
`default_nettype none

// Servo PWM position generator. Every word on in_ch is a timer tick, an
// absolute angle command or a relative angle command, and each one yields
// exactly one result word on out_ch (output level, pending angle, active
// angle after that word). Throughput is one word per clock while in_ch.ready
// is high: the whole state update (counter step, period wrap, angle latch,
// high time multiply-add-cap, command clamp) sits between the state registers
// and the result register, so each result is registered in the output stage.
// A two-entry output stage (result plus skid register) keeps in_ch.ready high
// while one result waits; in_ch.ready drops only when both entries are full.
// Commands only change the pending angle; it takes effect at the next period
// start; register changes act on later words. Register writes on cfg_ch are
// always taken (cfg_ch.ready is tied high) and must be made while the block
// is idle. After reset the angle is 90 degrees and the output level is high.
module servo_pwm_position_generator_top #(
  parameter int COUNT_WIDTH = spm_pkg::COUNT_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spm_in_if.sink    in_ch,
  spm_out_if.source out_ch,
  spm_cfg_if.sink   cfg_ch
);
  import spm_pkg::*;

  cfg_t   cfg;
  cmd_t   cmd;
  res_t   res;
  res_t   res_out;
  state_t st;
  logic   in_ready;
  logic   in_fire;

  // register file takes every write
  assign cfg_ch.ready = 1'b1;

  spm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_ch.valid),
    .idx_i   (cfg_ch.idx),
    .wdata_i (cfg_ch.wdata),
    .cfg_o   (cfg)
  );

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  assign cmd.op        = in_ch.op;
  assign cmd.abs_angle = in_ch.abs_angle;
  assign cmd.rel_delta = in_ch.rel_delta;

  // advance the servo state on every accepted word
  spm_core #(
    .CountWidth (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_fire),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .res_o  (res),
    .st_o   (st)
  );

  // hold results until the sink takes them
  spm_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .data_i  (res),
    .ready_o (in_ready),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .data_o  (res_out)
  );

  assign out_ch.pwm_level     = res_out.pwm_level;
  assign out_ch.pending_angle = res_out.pending_angle;
  assign out_ch.active_angle  = res_out.active_angle;

`ifndef NO_ASSERTIONS
  // a full output stage always shows a result
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result pending");

  // commands never move the output level
  a_cmd_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (cmd.op != OP_TICK) |=> st.phase_high == $past(st.phase_high))
    else $error("command changed the output level");

  // an absolute command never leaves a pending angle above max angle
  a_abs_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (cmd.op == OP_ABS) |=> st.nxt_angle <= $past(cfg.max_angle))
    else $error("absolute angle not clamped");

  // commands never touch the angle in force
  a_cmd_keeps_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (cmd.op != OP_TICK) |=> st.cur_angle == $past(st.cur_angle))
    else $error("command changed the active angle");
`endif

endmodule

`default_nettype wire
